// ===== hw/rtl/rptmt_pkg.sv =====
// Package: payload words, command and status codes, controller states.
package rptmt_pkg;

    localparam int LEVEL_BITS = 9;
    localparam int LEVELS     = 4;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_RANGE   = 2'd2,
        ST_POOL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [35:0] page;
        logic [19:0] frame;
        logic [9:0]  count;
        logic [15:0] flags;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] frame_out;
    } rsp_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_IDX,
        S_DISPATCH,
        S_RD,
        S_CHK,
        S_POOL,
        S_CLR,
        S_LINK,
        S_RANGE,
        S_FILL,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/radix_page_table_map_translate.sv =====
// Four-level radix page table with map, unmap and translate over one table memory.
//
//  channel  | handshake    | word
//  ---------+--------------+----------------------------------------------
//  request  | start, busy  | request: command, page, frame, count, flags
//  result   | done         | result: status, frame_out
//
// One command at a time; busy stays high from acceptance until the result strobe.
// Steps: the level indices are set up, then the table walk reads and checks each level;
// a map checks the pool, clears every table it takes entry by entry and links each new
// table below the root; map and unmap then check the range and write the leaf entries
// one by one before the result, all paced by the single table memory port.
// Reset empties the pool and drops the root; the memory itself is not cleared,
// every table is cleared as it is taken. The receiver cannot stall: done lasts one cycle.
module radix_page_table_map_translate #(
    parameter int ENTRIES_PER_TABLE = 512,
    parameter int TABLE_POOL        = 64,
    parameter int FRAME_BITS        = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rptmt_pkg::req_word_t  request,
    output logic                  busy,
    output logic                  done,
    output rptmt_pkg::rsp_word_t  result
);

    localparam int EW    = FRAME_BITS + 17;
    localparam int IB    = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
    localparam int TW    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int PW    = $clog2(TABLE_POOL + 1);
    localparam int CW    = PW + 3;
    localparam int DEPTH = TABLE_POOL * ENTRIES_PER_TABLE;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int SW    = 14;
    localparam int RSH   = 20;
    localparam int MW    = 21;
    localparam logic [MW-1:0] RECIP =
        MW'(((1 << RSH) + ENTRIES_PER_TABLE - 1) / ENTRIES_PER_TABLE);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    rptmt_pkg::state_t    state_reg, state_next;
    rptmt_pkg::req_word_t req_reg, req_next;
    logic [8:0]           q_reg   [rptmt_pkg::LEVELS];
    logic [8:0]           q_next  [rptmt_pkg::LEVELS];
    logic [IB-1:0]        idx_reg [rptmt_pkg::LEVELS];
    logic [IB-1:0]        idx_next[rptmt_pkg::LEVELS];
    logic [1:0]           lv_reg, lv_next;
    logic [TW-1:0]        t_reg, t_next;
    logic [TW-1:0]        clr_t_reg, clr_t_next;
    logic [PW-1:0]        nf_reg, nf_next;
    logic                 root_reg, root_next;
    logic                 phase_reg, phase_next;
    logic                 ret_root_reg, ret_root_next;
    logic [2:0]           need_reg, need_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [1:0]           status_reg, status_next;
    logic [19:0]          fout_reg, fout_next;

    logic [TW-1:0]        a_t;
    logic [IB-1:0]        a_i;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;
    logic [EW-1:0]        mem_wd;
    logic [8:0]           raw [rptmt_pkg::LEVELS];
    logic [SW-1:0]        leaf_end;
    logic [IB-1:0]        leaf_pos;
    logic                 rd_valid;
    logic [TW-1:0]        rd_ptr;

    always_comb
    begin
        for (int l = 0; l < rptmt_pkg::LEVELS; l++)
        begin
            raw[l] = req_reg.page[(3 - l) * rptmt_pkg::LEVEL_BITS +: rptmt_pkg::LEVEL_BITS];
        end
    end

    assign leaf_end = SW'(idx_reg[3]) + SW'(req_reg.count);
    assign leaf_pos = IB'(SW'(idx_reg[3]) + SW'(k_reg));
    assign rd_valid = rd_data_reg[EW-1];
    assign rd_ptr   = rd_data_reg[TW-1:0];
    assign mem_addr = AW'(AW'(a_t) * AW'(ENTRIES_PER_TABLE)) + AW'(a_i);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rptmt_pkg::S_IDLE;
            nf_reg    <= '0;
            root_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            root_reg  <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        q_reg        <= q_next;
        idx_reg      <= idx_next;
        lv_reg       <= lv_next;
        t_reg        <= t_next;
        clr_t_reg    <= clr_t_next;
        phase_reg    <= phase_next;
        ret_root_reg <= ret_root_next;
        need_reg     <= need_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        fout_reg     <= fout_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        q_next        = q_reg;
        idx_next      = idx_reg;
        lv_next       = lv_reg;
        t_next        = t_reg;
        clr_t_next    = clr_t_reg;
        nf_next       = nf_reg;
        root_next     = root_reg;
        phase_next    = phase_reg;
        ret_root_next = ret_root_reg;
        need_next     = need_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        fout_next     = fout_reg;
        a_t           = t_reg;
        a_i           = idx_reg[lv_reg];
        mem_we        = 1'b0;
        mem_wd        = '0;

        unique case (state_reg)
            rptmt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = rptmt_pkg::S_DIV;
                end
            end
            rptmt_pkg::S_DIV:
            begin
                for (int l = 0; l < rptmt_pkg::LEVELS; l++)
                begin
                    q_next[l] = 9'((30'(raw[l]) * 30'(RECIP)) >> RSH);
                end
                state_next = rptmt_pkg::S_IDX;
            end
            rptmt_pkg::S_IDX:
            begin
                for (int l = 0; l < rptmt_pkg::LEVELS; l++)
                begin
                    idx_next[l] = IB'(22'(raw[l]) - 22'(q_reg[l]) * 22'(ENTRIES_PER_TABLE));
                end
                state_next = rptmt_pkg::S_DISPATCH;
            end
            rptmt_pkg::S_DISPATCH:
            begin
                status_next = rptmt_pkg::ST_OK;
                fout_next   = '0;
                lv_next     = '0;
                t_next      = '0;
                phase_next  = 1'b0;
                case (req_reg.command) inside
                    rptmt_pkg::CMD_MAP:
                    begin
                        if (!root_reg)
                        begin
                            need_next  = 3'd4;
                            state_next = rptmt_pkg::S_POOL;
                        end
                        else
                        begin
                            state_next = rptmt_pkg::S_RD;
                        end
                    end
                    rptmt_pkg::CMD_UNMAP, rptmt_pkg::CMD_TRANSLATE:
                    begin
                        if (!root_reg)
                        begin
                            status_next = rptmt_pkg::ST_MISSING;
                            state_next  = rptmt_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = rptmt_pkg::S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = rptmt_pkg::S_DONE;
                    end
                endcase
            end
            rptmt_pkg::S_RD:
            begin
                state_next = rptmt_pkg::S_CHK;
            end
            rptmt_pkg::S_CHK:
            begin
                if (lv_reg == 2'd3)
                begin
                    if (rd_valid)
                    begin
                        fout_next = 20'(rd_data_reg[FRAME_BITS-1:0]);
                    end
                    else
                    begin
                        status_next = rptmt_pkg::ST_MISSING;
                    end
                    state_next = rptmt_pkg::S_DONE;
                end
                else if (rd_valid)
                begin
                    t_next = rd_ptr;
                    if (lv_reg == 2'd2)
                    begin
                        if (req_reg.command == rptmt_pkg::CMD_TRANSLATE)
                        begin
                            lv_next    = 2'd3;
                            state_next = rptmt_pkg::S_RD;
                        end
                        else if (req_reg.command == rptmt_pkg::CMD_MAP && !phase_reg)
                        begin
                            need_next  = '0;
                            state_next = rptmt_pkg::S_POOL;
                        end
                        else
                        begin
                            state_next = rptmt_pkg::S_RANGE;
                        end
                    end
                    else
                    begin
                        lv_next    = lv_reg + 2'd1;
                        state_next = rptmt_pkg::S_RD;
                    end
                end
                else if (req_reg.command != rptmt_pkg::CMD_MAP)
                begin
                    status_next = rptmt_pkg::ST_MISSING;
                    state_next  = rptmt_pkg::S_DONE;
                end
                else if (!phase_reg)
                begin
                    need_next  = 3'd3 - {1'b0, lv_reg};
                    state_next = rptmt_pkg::S_POOL;
                end
                else
                begin
                    clr_t_next    = TW'(nf_reg);
                    nf_next       = nf_reg + PW'(1);
                    k_next        = '0;
                    ret_root_next = 1'b0;
                    state_next    = rptmt_pkg::S_CLR;
                end
            end
            rptmt_pkg::S_POOL:
            begin
                lv_next    = '0;
                t_next     = '0;
                phase_next = 1'b1;
                k_next     = '0;
                if (CW'(need_reg) > CW'(TABLE_POOL) - CW'(nf_reg))
                begin
                    status_next = rptmt_pkg::ST_POOL;
                    state_next  = rptmt_pkg::S_DONE;
                end
                else if (!root_reg)
                begin
                    clr_t_next    = TW'(nf_reg);
                    nf_next       = nf_reg + PW'(1);
                    root_next     = 1'b1;
                    ret_root_next = 1'b1;
                    state_next    = rptmt_pkg::S_CLR;
                end
                else
                begin
                    state_next = rptmt_pkg::S_RD;
                end
            end
            rptmt_pkg::S_CLR:
            begin
                a_t    = clr_t_reg;
                a_i    = IB'(k_reg);
                mem_we = 1'b1;
                k_next = k_reg + KW'(1);
                if (k_reg == KW'(ENTRIES_PER_TABLE - 1))
                begin
                    k_next     = '0;
                    state_next = ret_root_reg ? rptmt_pkg::S_RD : rptmt_pkg::S_LINK;
                end
            end
            rptmt_pkg::S_LINK:
            begin
                mem_we = 1'b1;
                mem_wd = {1'b1, (EW-1)'(clr_t_reg)};
                t_next = clr_t_reg;
                if (lv_reg == 2'd2)
                begin
                    state_next = rptmt_pkg::S_RANGE;
                end
                else
                begin
                    lv_next    = lv_reg + 2'd1;
                    state_next = rptmt_pkg::S_RD;
                end
            end
            rptmt_pkg::S_RANGE:
            begin
                k_next = '0;
                if (leaf_end > SW'(ENTRIES_PER_TABLE))
                begin
                    status_next = rptmt_pkg::ST_RANGE;
                    state_next  = rptmt_pkg::S_DONE;
                end
                else if (req_reg.count == '0)
                begin
                    state_next = rptmt_pkg::S_DONE;
                end
                else
                begin
                    state_next = rptmt_pkg::S_FILL;
                end
            end
            rptmt_pkg::S_FILL:
            begin
                a_i    = leaf_pos;
                mem_we = 1'b1;
                if (req_reg.command == rptmt_pkg::CMD_MAP)
                begin
                    mem_wd = {1'b1, req_reg.flags, FRAME_BITS'(req_reg.frame)};
                end
                k_next = k_reg + KW'(1);
                if (SW'(k_reg) + SW'(1) == SW'(req_reg.count))
                begin
                    state_next = rptmt_pkg::S_DONE;
                end
            end
            rptmt_pkg::S_DONE:
            begin
                state_next = rptmt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rptmt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != rptmt_pkg::S_IDLE);
    assign done             = (state_reg == rptmt_pkg::S_DONE);
    assign result.status    = status_reg;
    assign result.frame_out = fout_reg;

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= PW'(TABLE_POOL))
        else $error("pool counter past pool size");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.frame_out != '0 |-> result.status == rptmt_pkg::ST_OK)
        else $error("frame returned with failing status");
    a_root_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(root_reg) |-> root_reg)
        else $error("root lost");
`endif

endmodule
